>>> src/assert_macros.svh
// assertion macros shared by the track event parser modules
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define SMF_ASSERT_NEVER(label, cond, msg) `SMF_ASSERT(label, !(cond), msg)

`endif

>>> src/smftep_pkg.sv
// types and constants of the midi file track event parser
// no dependencies
package smftep_pkg;

  localparam int TRACKS_DEF = 16;
  localparam int QDEPTH_DEF = 2;
  localparam int MAX_RES = 4;

  // per-track parse phase codes
  localparam logic [3:0] PH_DELTA      = 4'd0;
  localparam logic [3:0] PH_EVENT      = 4'd1;
  localparam logic [3:0] PH_META_TYPE  = 4'd2;
  localparam logic [3:0] PH_META_LEN   = 4'd3;
  localparam logic [3:0] PH_META_SKIP  = 4'd4;
  localparam logic [3:0] PH_TEMPO      = 4'd5;
  localparam logic [3:0] PH_DATA_SEND  = 4'd6;
  localparam logic [3:0] PH_DATA_DROP  = 4'd7;
  localparam logic [3:0] PH_SYSEX_LEN  = 4'd8;
  localparam logic [3:0] PH_SYSEX_DATA = 4'd9;
  localparam logic [3:0] PH_DONE       = 4'd10;

  // result kinds
  localparam logic [2:0] K_MIDI  = 3'd0;
  localparam logic [2:0] K_TEMPO = 3'd1;
  localparam logic [2:0] K_EOT   = 3'd2;
  localparam logic [2:0] K_ERROR = 3'd3;
  localparam logic [2:0] K_ENDED = 3'd4;

  // special bytes
  localparam logic [7:0] B_META     = 8'hFF;
  localparam logic [7:0] B_EOT      = 8'h2F;
  localparam logic [7:0] B_TEMPO    = 8'h51;
  localparam logic [7:0] B_EOX      = 8'hF7;
  localparam logic [7:0] B_RESET    = 8'hFF;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  rs;
    logic [31:0] acc;
    logic [31:0] rem;
    logic [7:0]  meta;
    logic [23:0] tempo;
    logic [63:0] pos;
    logic        active;
  } trk_state_t;

  localparam int STATE_W = $bits(trk_state_t);

  localparam trk_state_t RESET_ST = '{
    phase: PH_DELTA, rs: 8'h00, acc: 32'h0, rem: 32'h0, meta: 8'h00,
    tempo: 24'h0, pos: 64'h0, active: 1'b1
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] value;
    logic [63:0] etime;
  } res_t;

  // all results caused by one item
  typedef struct packed {
    logic [3:0]  trk;
    logic [2:0]  cnt;
    res_t [MAX_RES-1:0] r;
  } bundle_t;

endpackage

>>> src/smftep_ram.sv
// generic single write port ram with registered read
// no dependencies
module smftep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/smftep_front.sv
// front end: accepts items, looks up per-track state, parses one byte
// depends on smftep_pkg, smftep_ram and assert_macros.svh
`include "assert_macros.svh"
module smftep_front import smftep_pkg::*; #(
  parameter int TRACKS = TRACKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [3:0] track,
  input  logic [7:0] data_byte,
  input  logic       chunk_end,
  output logic       q_push,
  output bundle_t    q_data,
  input  logic       q_full
);

  localparam int AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  logic       s1_v;
  logic       s1_func;
  logic [3:0] s1_trk;
  logic [7:0] s1_b;
  logic       s1_end;
  logic       s1_go;
  logic       accept;
  logic       wr_en;
  logic [AW-1:0] s1_addr;
  logic [STATE_W-1:0] ram_q;
  logic [TRACKS-1:0] vld;
  logic       lw_v;
  logic [3:0] lw_trk;
  trk_state_t lw_st;
  trk_state_t cur;
  trk_state_t st;
  bundle_t    bd;
  logic [31:0] acc2;

  assign s1_go  = !q_full;
  assign full   = s1_v && q_full;
  assign accept = push && !full;
  assign s1_addr = AW'(s1_trk);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (s1_go) begin
      s1_v <= 1'b0;
    end
    if (accept) begin
      s1_func <= func;
      s1_trk  <= track;
      s1_b    <= data_byte;
      s1_end  <= chunk_end;
    end
  end

  smftep_ram #(.WIDTH(STATE_W), .DEPTH(TRACKS)) u_state (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (st),
    .re    (accept),
    .raddr (AW'(track)),
    .rdata (ram_q)
  );

  // valid bits stand in for the reset value, last write covers read-old hazard
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      lw_v <= 1'b0;
    end else if (wr_en) begin
      vld[s1_addr] <= 1'b1;
      lw_v <= 1'b1;
    end
    if (wr_en) begin
      lw_trk <= s1_trk;
      lw_st  <= st;
    end
  end

  function automatic void emit(inout bundle_t b, input logic [2:0] k,
                               input logic [23:0] v, input logic [63:0] t);
    b.r[b.cnt[1:0]].kind  = k;
    b.r[b.cnt[1:0]].value = v;
    b.r[b.cnt[1:0]].etime = t;
    b.cnt = b.cnt + 3'd1;
  endfunction

  function automatic trk_state_t to_delta(input trk_state_t s);
    trk_state_t o;
    o = s;
    o.acc = '0;
    o.phase = PH_DELTA;
    return o;
  endfunction

  function automatic trk_state_t begin_cmd(input trk_state_t s);
    trk_state_t o;
    o = s;
    case (s.rs[7:4])
      4'hF: begin
        if (s.rs[3:0] inside {4'h0, 4'h7}) begin
          o.acc = '0;
          o.phase = PH_SYSEX_LEN;
        end else if (s.rs[3:0] inside {4'h1, 4'h3}) begin
          o.phase = PH_DATA_SEND;
          o.rem = 32'd1;
        end else if (s.rs[3:0] == 4'h2) begin
          o.phase = PH_DATA_SEND;
          o.rem = 32'd2;
        end else begin
          o = to_delta(s);
        end
      end
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
        o.phase = PH_DATA_SEND;
        o.rem = 32'd2;
      end
      4'hC, 4'hD: begin
        o.phase = PH_DATA_SEND;
        o.rem = 32'd1;
      end
      default: begin
        o.phase = PH_DATA_DROP;
        o.rem = 32'd1;
      end
    endcase
    return o;
  endfunction

  function automatic trk_state_t count_down(input trk_state_t s);
    trk_state_t o;
    o = s;
    if (s.rem != 32'd0) begin
      o.rem = s.rem - 32'd1;
    end
    if (o.rem == 32'd0) begin
      o = to_delta(o);
    end
    return o;
  endfunction

  always_comb begin
    if (lw_v && lw_trk == s1_trk) begin
      cur = lw_st;
    end else if (vld[s1_addr]) begin
      cur = trk_state_t'(ram_q);
    end else begin
      cur = RESET_ST;
    end
    st = cur;
    bd = '0;
    bd.trk = s1_trk;
    acc2 = '0;
    if (s1_func) begin
      st = RESET_ST;
    end else if (st.active && st.phase != PH_DONE) begin
      // data byte right after a delta time: resend running status first
      if (st.phase == PH_EVENT && !s1_b[7]) begin
        if (st.rs != B_EOX) begin
          emit(bd, K_MIDI, {16'h0, st.rs}, st.pos);
        end
        st = begin_cmd(st);
      end
      acc2 = {st.acc[24:0], s1_b[6:0]};
      case (st.phase)
        PH_DELTA: begin
          if (!s1_b[7]) begin
            st.pos = st.pos + {32'h0, acc2};
            st.acc = '0;
            st.phase = PH_EVENT;
          end else begin
            st.acc = acc2;
          end
        end
        PH_EVENT: begin
          if (s1_b == B_META) begin
            st.phase = PH_META_TYPE;
          end else begin
            st.rs = s1_b;
            if (s1_b != B_EOX) begin
              emit(bd, K_MIDI, {16'h0, s1_b}, st.pos);
            end
            st = begin_cmd(st);
          end
        end
        PH_META_TYPE: begin
          st.meta = s1_b;
          st.acc = '0;
          st.phase = PH_META_LEN;
        end
        PH_META_LEN: begin
          if (!s1_b[7]) begin
            st.acc = '0;
            if (st.meta == B_EOT) begin
              emit(bd, K_EOT, 24'h0, st.pos);
              st.phase = PH_DONE;
              st.active = 1'b0;
            end else if (st.meta == B_TEMPO) begin
              st.tempo = '0;
              st.phase = PH_TEMPO;
              st.rem = 32'd3;
            end else if (acc2 == 32'd0) begin
              st = to_delta(st);
            end else begin
              st.phase = PH_META_SKIP;
              st.rem = acc2;
            end
          end else begin
            st.acc = acc2;
          end
        end
        PH_META_SKIP, PH_DATA_DROP: begin
          st = count_down(st);
        end
        PH_TEMPO: begin
          st.tempo = {st.tempo[15:0], s1_b};
          if (st.rem <= 32'd1) begin
            emit(bd, K_TEMPO, st.tempo, st.pos);
          end
          st = count_down(st);
        end
        PH_DATA_SEND, PH_SYSEX_DATA: begin
          emit(bd, K_MIDI, {16'h0, s1_b}, st.pos);
          st = count_down(st);
        end
        PH_SYSEX_LEN: begin
          if (!s1_b[7]) begin
            st.acc = '0;
            if (acc2 == 32'd0) begin
              st = to_delta(st);
            end else begin
              st.phase = PH_SYSEX_DATA;
              st.rem = acc2;
            end
          end else begin
            st.acc = acc2;
          end
        end
        default: begin
        end
      endcase
      // chunk ends: inside a command is an error, elsewhere the stream ended
      if (s1_end && st.active && st.phase != PH_DONE) begin
        if (st.phase inside {PH_DATA_SEND, PH_DATA_DROP, PH_SYSEX_LEN, PH_SYSEX_DATA}) begin
          emit(bd, K_MIDI, {16'h0, B_RESET}, st.pos);
          emit(bd, K_ERROR, 24'h0, st.pos);
        end else begin
          emit(bd, K_ENDED, 24'h0, st.pos);
        end
        st.phase = PH_DONE;
        st.active = 1'b0;
      end
    end
  end

  assign wr_en  = s1_v && s1_go && (32'(s1_trk) < TRACKS);
  assign q_push = wr_en && (bd.cnt != 3'd0);
  assign q_data = bd;

  `SMF_ASSERT(a_hold_on_stall, (s1_v && !s1_go) |=> (s1_v && $stable(s1_trk)), "front lost a stalled item")

endmodule

>>> src/smftep_fifo.sv
// short queue of result bundles between front and back end
// depends on smftep_pkg and assert_macros.svh
`include "assert_macros.svh"
module smftep_fifo import smftep_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  bundle_t wdata,
  output logic    full,
  input  logic    rd,
  output bundle_t rdata,
  output logic    empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic do_wr;
  logic do_rd;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CW'(1);
      end
    end
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  `SMF_ASSERT(a_cnt_bound, cnt <= CW'(DEPTH), "queue count beyond depth")

endmodule

>>> src/smftep_back.sv
// back end: hands out the results of each bundle one at a time
// depends on smftep_pkg and assert_macros.svh
`include "assert_macros.svh"
module smftep_back import smftep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bundle_t     q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_track,
  output logic [2:0]  kind,
  output logic [23:0] value,
  output logic [63:0] event_time,
  output logic        last
);

  logic [1:0] sel;
  logic       take;

  assign empty      = q_empty;
  assign take       = pop && !q_empty;
  assign out_track  = q_data.trk;
  assign kind       = q_data.r[sel].kind;
  assign value      = q_data.r[sel].value;
  assign event_time = q_data.r[sel].etime;
  assign last       = ({1'b0, sel} + 3'd1 == q_data.cnt);
  assign q_pop      = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else if (take) begin
      sel <= last ? 2'd0 : sel + 2'd1;
    end
  end

  `SMF_ASSERT(a_sel_in_bundle, !q_empty |-> (q_data.cnt != 3'd0 && {1'b0, sel} < q_data.cnt), "result select outside bundle")

endmodule

>>> src/smf_track_event_parser.sv
// top level of the midi file track event parser
// depends on smftep_pkg, smftep_front, smftep_fifo and smftep_back
//
// usage:
// - input channel is a queue write port: an item (func, track, data_byte,
//   chunk_end) is taken on a clock edge with push high and full low
// - result channel is a queue read port: while empty is low the oldest
//   result (out_track, kind, value, event_time, last) is on the ports, and
//   it is taken on a clock edge with pop high
// - each item gives zero to four results; last marks the final one of an item
// - one item per cycle is taken while full is low; the per-track state lives
//   in a ram with a registered read, and a write-forward register lets the
//   same track follow itself in the next cycle
// - an item is registered in the front stage, and its results are written to
//   the bundle queue, whose head bundle drives the result ports
// - results leave one per cycle while pop is high, so items with several
//   results fill the bundle queue and full rises until the back end drains it
// - when the receiver stalls the queue fills, then the front holds its item
//   and full stays high; nothing is dropped
// - reset clears the pipeline, the queue and the per-track valid bits, so all
//   tracks start from the reset state once reset is released
module smf_track_event_parser import smftep_pkg::*; #(
  parameter int TRACKS = TRACKS_DEF,
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [3:0]  track,
  input  logic [7:0]  data_byte,
  input  logic        chunk_end,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_track,
  output logic [2:0]  kind,
  output logic [23:0] value,
  output logic [63:0] event_time,
  output logic        last
);

  // bundle queue between parse and serialize
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_wdata;
  bundle_t q_rdata;

  // parse one byte per cycle against its track state while the queue has room
  smftep_front #(.TRACKS(TRACKS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .track     (track),
    .data_byte (data_byte),
    .chunk_end (chunk_end),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  smftep_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // one result per cycle out of the head bundle while pop is high
  smftep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_track  (out_track),
    .kind       (kind),
    .value      (value),
    .event_time (event_time),
    .last       (last)
  );

endmodule
